/* hw/rtl/multi_voice_tone_sequencer_macros.svh */
// Assertion macros for the tone sequencer.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef MULTI_VOICE_TONE_SEQUENCER_MACROS_SVH
`define MULTI_VOICE_TONE_SEQUENCER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MVTS_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("sequencer check failed");
`define MVTS_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("sequencer check failed");
`else
`define MVTS_ASSERT_NOW(lbl, pre, post)
`define MVTS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* hw/rtl/mvts_pkg.sv */
// Shared types, codes and helper functions of the tone sequencer.
// Depends on nothing; every RTL module uses it by scoped names.
package mvts_pkg;

	localparam int VOICES    = 5;
	localparam int NOTES     = 256;
	localparam int VOICE_W   = 3;
	localparam int IDX_W     = 8;
	localparam int POS_W     = $clog2(NOTES) + 1;
	localparam int ADDR_W    = $clog2(VOICES * NOTES);
	localparam int ELA_W     = 24;
	localparam int LVL_W     = 32;
	localparam int THR_W     = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// Command codes.
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// Note kinds.
	localparam logic [1:0] KIND_SOUND = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_SYNC  = 2'd2;

	// Event codes.
	localparam logic [1:0] EV_DRIVE = 2'd0;
	localparam logic [1:0] EV_STOP  = 2'd1;
	localparam logic [1:0] EV_DONE  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BEAT_TICKS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEN0       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_DUTY  = 3'd7;

	typedef struct packed {
		logic [1:0]  command;
		logic [2:0]  voice;
		logic [7:0]  note_index;
		logic [6:0]  tone_code;
		logic [1:0]  note_kind;
		logic [7:0]  beats;
		logic [15:0] base_volume;
		logic [8:0]  first_duty;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [2:0]  out_voice;
		logic [6:0]  out_tone;
		logic        timer_off;
		logic [15:0] pulse_level;
		logic        force_update;
		logic        last_of_tick;
	} evt_word_t;

	// One entry of the note memory.
	typedef struct packed {
		logic [6:0]  tone;
		logic [1:0]  kind;
		logic [7:0]  beats;
		logic [15:0] base;
		logic [8:0]  duty;
	} note_t;

	// Flat note memory address of a voice and note position.
	function automatic logic [ADDR_W-1:0] note_addr(input logic [VOICE_W-1:0] v,
		input logic [IDX_W-1:0] idx);
		logic [2*ADDR_W-1:0] prod;
		prod = (2*ADDR_W)'(v) * (2*ADDR_W)'(NOTES);
		return prod[ADDR_W-1:0] + ADDR_W'(idx);
	endfunction

	// Start level in 16.16: base times a Q1.8 duty, saturated to 32 bits.
	function automatic logic [LVL_W-1:0] start_level(input logic [15:0] base,
		input logic [8:0] duty);
		logic [24:0] prod;
		logic [32:0] wide;
		prod = 25'(base) * 25'(duty);
		wide = {prod, 8'd0};
		return wide[32] ? {LVL_W{1'b1}} : wide[31:0];
	endfunction

endpackage

/* hw/rtl/multi_voice_tone_sequencer.sv */
// Tone sequencer top level. A load word is written to the note memory as it is taken; a start
// walks the voices and arms each enabled voice that is not yet running. A tick walks the voices:
// it passes a disabled voice, stops an exhausted one, reads, decays and drives a live one, and
// on a sync rest checks whether every live voice rests on sync and then advances all of them;
// with no notes left it emits a finished word. Output stalls hold the walk in its emitting states.
// Reset (arst_n low) clears positions, levels and registers at once; the note memory is not cleared.
`include "multi_voice_tone_sequencer_macros.svh"
module multi_voice_tone_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  mvts_pkg::cmd_word_t            cmd_word,
	output logic                           evt_valid,
	input  logic                           evt_ready,
	output mvts_pkg::evt_word_t            evt_word,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mvts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mvts_pkg::CFG_DAT_W-1:0] cfg_data
);

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_ST_RD  = 12'b0000_0000_0010,
		S_ST_WR  = 12'b0000_0000_0100,
		S_T_SEL  = 12'b0000_0000_1000,
		S_T_D1   = 12'b0000_0001_0000,
		S_T_D2   = 12'b0000_0010_0000,
		S_T_EMIT = 12'b0000_0100_0000,
		S_SY_SEL = 12'b0000_1000_0000,
		S_SY_CHK = 12'b0001_0000_0000,
		S_AD_SEL = 12'b0010_0000_0000,
		S_AD_WR  = 12'b0100_0000_0000,
		S_FIN    = 12'b1000_0000_0000
	} state_t;

	localparam int V  = mvts_pkg::VOICES;
	localparam int PW = mvts_pkg::POS_W;
	localparam int VW = mvts_pkg::VOICE_W;
	localparam int EW = mvts_pkg::ELA_W;
	localparam int LW = mvts_pkg::LVL_W;
	localparam logic [VW-1:0] LAST_V  = VW'(V - 1);
	localparam logic [EW-1:0] ELA_MAX = {EW{1'b1}};

	state_t          state_q;
	logic [VW-1:0]   cur_q;
	logic [VW-1:0]   p_q;
	logic            all_q;
	logic [mvts_pkg::THR_W-1:0] thr_q;

	logic [PW-1:0]   pos_q [V];
	logic [EW-1:0]   ela_q [V];
	logic [LW-1:0]   lvl_q [V];
	logic [V-1:0]    run_q;

	logic [15:0]     beat_ticks_q;
	logic [4:0]      enable_q;
	logic [8:0]      len_q [V];
	logic [8:0]      init_duty_q;

	logic                  evt_valid_q;
	mvts_pkg::evt_word_t   evt_word_q;

	logic [PW-1:0]   eff_len [V];
	logic [V-1:0]    has_notes;
	logic            any_notes;
	logic            cur_on;
	logic            cur_last;
	logic            cur_end;
	logic            p_end;
	logic [PW-1:0]   cur_pos;
	logic [PW-1:0]   pos_inc;
	logic [EW-1:0]   ela_inc;
	logic            adv_one;
	logic            out_free;
	logic            cmd_take;

	logic                          mem_we;
	logic [mvts_pkg::ADDR_W-1:0]   mem_waddr;
	mvts_pkg::note_t               mem_wdata;
	logic                          mem_re;
	logic [mvts_pkg::ADDR_W-1:0]   mem_raddr;
	mvts_pkg::note_t               rd;
	logic [LW-1:0]                 dec_lv;

	logic                emit_en;
	mvts_pkg::evt_word_t emit_word;

	// Offset of a voice's length register from the first one.
	function automatic logic [mvts_pkg::CFG_IDX_W-1:0] CFG_IDX_OFS(input int v);
		return mvts_pkg::CFG_IDX_W'(v);
	endfunction

	// Per-voice length clamp and note availability.
	always_comb begin
		for (int v = 0; v < V; v++) begin
			eff_len[v]   = (len_q[v] > 9'(mvts_pkg::NOTES)) ? PW'(mvts_pkg::NOTES)
				: PW'(len_q[v]);
			has_notes[v] = enable_q[v] && (pos_q[v] < eff_len[v]);
		end
		any_notes = |has_notes;
	end

	// Facts about the voice under the cursor.
	always_comb begin
		cur_on   = enable_q[cur_q];
		cur_pos  = pos_q[cur_q];
		pos_inc  = cur_pos + PW'(1);
		ela_inc  = (ela_q[cur_q] == ELA_MAX) ? ELA_MAX : ela_q[cur_q] + EW'(1);
		cur_end  = cur_q == LAST_V;
		p_end    = p_q == LAST_V;
		cur_last = 1'b1;
		for (int v = 0; v < V; v++) begin
			if (VW'(v) > cur_q && enable_q[v]) begin
				cur_last = 1'b0;
			end
		end
		adv_one  = (rd.kind != mvts_pkg::KIND_SYNC) && (ela_inc >= thr_q);
	end

	assign out_free  = !evt_valid_q || evt_ready;
	assign cmd_ready = state_q == S_IDLE;
	assign cmd_take  = cmd_valid && cmd_ready;
	assign cfg_ready = 1'b1;
	assign evt_valid = evt_valid_q;
	assign evt_word  = evt_word_q;

	// Note memory ports.
	always_comb begin
		mem_we          = cmd_take && (cmd_word.command == mvts_pkg::CMD_LOAD)
			&& (cmd_word.voice < VW'(V));
		mem_waddr       = mvts_pkg::note_addr(cmd_word.voice, cmd_word.note_index);
		mem_wdata.tone  = cmd_word.tone_code;
		mem_wdata.kind  = cmd_word.note_kind;
		mem_wdata.beats = cmd_word.beats;
		mem_wdata.base  = cmd_word.base_volume;
		mem_wdata.duty  = cmd_word.first_duty;
		mem_re          = 1'b0;
		mem_raddr       = mvts_pkg::note_addr(cur_q, cur_pos[mvts_pkg::IDX_W-1:0]);
		case (state_q)
			S_ST_RD: begin
				mem_re    = 1'b1;
				mem_raddr = mvts_pkg::note_addr(cur_q, '0);
			end
			S_T_SEL, S_SY_SEL: begin
				mem_re = 1'b1;
			end
			S_AD_SEL: begin
				mem_re    = 1'b1;
				mem_raddr = mvts_pkg::note_addr(cur_q, pos_inc[mvts_pkg::IDX_W-1:0]);
			end
			S_T_EMIT: begin
				mem_re    = out_free && adv_one;
				mem_raddr = mvts_pkg::note_addr(cur_q, pos_inc[mvts_pkg::IDX_W-1:0]);
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	mvts_note_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd)
	);

	mvts_decay u_decay (
		.clk     (clk),
		.lv      (lvl_q[cur_q]),
		.base    (rd.base),
		.lv_next (dec_lv)
	);

	// Result word built in the emitting states.
	always_comb begin
		emit_en   = 1'b0;
		emit_word = '0;
		case (state_q)
			S_T_SEL: begin
				emit_en                = out_free && cur_on && !has_notes[cur_q];
				emit_word.event_kind   = mvts_pkg::EV_STOP;
				emit_word.out_voice    = cur_q;
				emit_word.last_of_tick = cur_last;
			end
			S_T_EMIT: begin
				emit_en                = out_free;
				emit_word.event_kind   = mvts_pkg::EV_DRIVE;
				emit_word.out_voice    = cur_q;
				emit_word.out_tone     = rd.tone;
				emit_word.timer_off    = rd.beats == 8'd0;
				emit_word.pulse_level  = (rd.kind != mvts_pkg::KIND_SOUND) ? 16'd0
					: dec_lv[31:16];
				emit_word.force_update = ela_q[cur_q] == '0;
				emit_word.last_of_tick = cur_last;
			end
			S_FIN: begin
				emit_en                = out_free;
				emit_word.event_kind   = mvts_pkg::EV_DONE;
				emit_word.last_of_tick = 1'b1;
			end
			default: begin
				emit_en = 1'b0;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (emit_en) begin
			evt_valid_q <= 1'b1;
		end else if (evt_ready) begin
			evt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			evt_word_q <= emit_word;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_ticks_q <= 16'd1;
			enable_q     <= '0;
			init_duty_q  <= 9'd128;
			for (int v = 0; v < V; v++) begin
				len_q[v] <= '0;
			end
		end else if (cfg_valid) begin
			if (cfg_index == mvts_pkg::CFG_BEAT_TICKS) begin
				beat_ticks_q <= cfg_data;
			end
			if (cfg_index == mvts_pkg::CFG_ENABLE) begin
				enable_q <= cfg_data[4:0];
			end
			if (cfg_index == mvts_pkg::CFG_INIT_DUTY) begin
				init_duty_q <= cfg_data[8:0];
			end
			for (int v = 0; v < V; v++) begin
				if (cfg_index == mvts_pkg::CFG_LEN0 + CFG_IDX_OFS(v)) begin
					len_q[v] <= cfg_data[8:0];
				end
			end
		end
	end

	// Sequencer: walks the voices, reads notes and updates voice state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q   <= '0;
			p_q     <= '0;
			all_q   <= 1'b0;
			thr_q   <= '0;
			run_q   <= '0;
			for (int v = 0; v < V; v++) begin
				pos_q[v] <= '0;
				ela_q[v] <= '0;
				lvl_q[v] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						cur_q <= '0;
						if (cmd_word.command == mvts_pkg::CMD_START) begin
							state_q <= S_ST_RD;
						end else if (cmd_word.command == mvts_pkg::CMD_TICK) begin
							state_q <= any_notes ? S_T_SEL : S_FIN;
						end
					end
				end
				S_ST_RD: begin
					if (cur_on && !run_q[cur_q]) begin
						state_q <= S_ST_WR;
					end else if (cur_end) begin
						state_q <= S_IDLE;
					end else begin
						cur_q <= cur_q + VW'(1);
					end
				end
				S_ST_WR: begin
					lvl_q[cur_q] <= (eff_len[cur_q] == '0) ? '0
						: mvts_pkg::start_level(rd.base, init_duty_q);
					run_q[cur_q] <= 1'b1;
					if (cur_end) begin
						state_q <= S_IDLE;
					end else begin
						cur_q   <= cur_q + VW'(1);
						state_q <= S_ST_RD;
					end
				end
				S_T_SEL: begin
					if (cur_on && has_notes[cur_q]) begin
						state_q <= S_T_D1;
					end else if (!cur_on || out_free) begin
						if (cur_on) begin
							run_q[cur_q] <= 1'b0;
						end
						if (cur_end) begin
							state_q <= S_IDLE;
						end else begin
							cur_q <= cur_q + VW'(1);
						end
					end
				end
				S_T_D1: begin
					state_q <= S_T_D2;
				end
				S_T_D2: begin
					thr_q   <= mvts_pkg::THR_W'(rd.beats) * mvts_pkg::THR_W'(beat_ticks_q);
					state_q <= S_T_EMIT;
				end
				S_T_EMIT: begin
					if (out_free) begin
						lvl_q[cur_q] <= dec_lv;
						p_q          <= cur_q;
						if (rd.kind == mvts_pkg::KIND_SYNC) begin
							ela_q[cur_q] <= ela_inc;
							cur_q        <= '0;
							state_q      <= S_SY_SEL;
						end else if (adv_one) begin
							ela_q[cur_q] <= '0;
							pos_q[cur_q] <= pos_inc;
							all_q        <= 1'b0;
							state_q      <= S_AD_WR;
						end else begin
							ela_q[cur_q] <= ela_inc;
							if (cur_end) begin
								state_q <= S_IDLE;
							end else begin
								cur_q   <= cur_q + VW'(1);
								state_q <= S_T_SEL;
							end
						end
					end
				end
				S_SY_SEL: begin
					if (has_notes[cur_q]) begin
						state_q <= S_SY_CHK;
					end else if (!cur_end) begin
						cur_q <= cur_q + VW'(1);
					end else begin
						cur_q   <= '0;
						all_q   <= 1'b1;
						state_q <= S_AD_SEL;
					end
				end
				S_SY_CHK: begin
					if (rd.kind != mvts_pkg::KIND_SYNC) begin
						if (p_end) begin
							state_q <= S_IDLE;
						end else begin
							cur_q   <= p_q + VW'(1);
							state_q <= S_T_SEL;
						end
					end else if (!cur_end) begin
						cur_q   <= cur_q + VW'(1);
						state_q <= S_SY_SEL;
					end else begin
						cur_q   <= '0;
						all_q   <= 1'b1;
						state_q <= S_AD_SEL;
					end
				end
				S_AD_SEL: begin
					if (has_notes[cur_q]) begin
						pos_q[cur_q] <= pos_inc;
						ela_q[cur_q] <= '0;
						state_q      <= S_AD_WR;
					end else if (!cur_end) begin
						cur_q <= cur_q + VW'(1);
					end else if (p_end) begin
						state_q <= S_IDLE;
					end else begin
						cur_q   <= p_q + VW'(1);
						state_q <= S_T_SEL;
					end
				end
				S_AD_WR: begin
					lvl_q[cur_q] <= (cur_pos >= eff_len[cur_q]) ? '0
						: mvts_pkg::start_level(rd.base, rd.duty);
					if (all_q && !cur_end) begin
						cur_q   <= cur_q + VW'(1);
						state_q <= S_AD_SEL;
					end else if (p_end) begin
						state_q <= S_IDLE;
					end else begin
						cur_q   <= p_q + VW'(1);
						state_q <= S_T_SEL;
					end
				end
				S_FIN: begin
					if (out_free) begin
						run_q   <= '0;
						state_q <= S_IDLE;
						for (int v = 0; v < V; v++) begin
							pos_q[v] <= '0;
							ela_q[v] <= '0;
							lvl_q[v] <= '0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Decay never raises a level.
	`MVTS_ASSERT_NOW(a_decay_falls, (state_q == S_T_EMIT), (dec_lv <= lvl_q[cur_q]))
	// A finished word always closes its tick.
	`MVTS_ASSERT_NOW(a_done_last, (evt_valid && evt_word.event_kind == mvts_pkg::EV_DONE),
		evt_word.last_of_tick)
	// After the finished word the first voice is back at its first note.
	`MVTS_ASSERT_NEXT(a_fin_clears, (state_q == S_FIN && out_free), (pos_q[0] == '0))

endmodule

/* hw/rtl/mvts_note_mem.sv */
// Note memory: one write port, one read port with registered read data.
// Depends on mvts_pkg for the entry type and the address width.
module mvts_note_mem (
	input  logic                       clk,
	input  logic                       we,
	input  logic [mvts_pkg::ADDR_W-1:0] waddr,
	input  mvts_pkg::note_t            wdata,
	input  logic                       re,
	input  logic [mvts_pkg::ADDR_W-1:0] raddr,
	output mvts_pkg::note_t            rdata
);

	mvts_pkg::note_t mem_q [mvts_pkg::VOICES * mvts_pkg::NOTES];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/mvts_decay.sv */
// Two-stage level decay: level*99/100 floored, or zero below base/1000.
// Depends on mvts_pkg for widths.
module mvts_decay (
	input  logic                      clk,
	input  logic [mvts_pkg::LVL_W-1:0] lv,
	input  logic [15:0]               base,
	output logic [mvts_pkg::LVL_W-1:0] lv_next
);

	// Reciprocal of 25 scaled by 2^36, rounded up.
	localparam logic [31:0] RECIP25 = 32'hA3D7_0A3E;

	logic [41:0] lv_x1000;
	logic [41:0] floor_lvl;
	logic [32:0] lv_round;
	logic        keep_s1;
	logic [30:0] quo_in_s1;
	logic [31:0] lv_s1;
	logic        keep_s2;
	logic [62:0] prod_s2;
	logic [31:0] lv_s2;

	// Stage one: threshold compare and ceil(lv/100) numerator.
	always_comb begin
		lv_x1000  = 42'(lv) * 42'd1000;
		floor_lvl = {10'd0, base, 16'd0};
		lv_round  = 33'(lv) + 33'd99;
	end

	always_ff @(posedge clk) begin
		keep_s1   <= lv_x1000 >= floor_lvl;
		quo_in_s1 <= lv_round[32:2];
		lv_s1     <= lv;
	end

	// Stage two: divide by 25 through the reciprocal.
	always_ff @(posedge clk) begin
		keep_s2 <= keep_s1;
		prod_s2 <= 63'(quo_in_s1) * 63'(RECIP25);
		lv_s2   <= lv_s1;
	end

	// floor(lv*99/100) equals lv minus ceil(lv/100).
	assign lv_next = keep_s2 ? lv_s2 - 32'(prod_s2[62:36]) : '0;

endmodule

/* bench/testbench.sv */
// Self-checking testbench of the five-voice tone sequencer.
// Depends on mvts_pkg and multi_voice_tone_sequencer; holds its own behavioral predictor.
module testbench;

	localparam logic [1:0] CMD_NONE  = 2'd3;
	localparam int unsigned ELA_MAX  = 24'hFFFFFF;
	localparam int DRAIN_CYCLES      = 64;
	localparam int HOLD_CYCLES       = 300;

	typedef struct {
		bit                             is_cfg;
		logic [mvts_pkg::CFG_IDX_W-1:0] idx;
		logic [mvts_pkg::CFG_DAT_W-1:0] data;
		mvts_pkg::cmd_word_t            word;
		bit                             typed;
		mvts_pkg::evt_word_t            want;
	} row_t;

	logic                           clk;
	logic                           arst_n    = 1'b0;
	logic                           cmd_valid = 1'b0;
	logic                           cmd_ready;
	mvts_pkg::cmd_word_t            cmd_word  = '0;
	logic                           evt_valid;
	logic                           evt_ready = 1'b0;
	mvts_pkg::evt_word_t            evt_word;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [mvts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [mvts_pkg::CFG_DAT_W-1:0] cfg_data  = '0;

	// Predicted sequencer state and register copies.
	mvts_pkg::note_t notes_mem [mvts_pkg::VOICES*mvts_pkg::NOTES];
	int unsigned     play_pos [mvts_pkg::VOICES];
	int unsigned     play_ela [mvts_pkg::VOICES];
	logic [31:0]     play_lvl [mvts_pkg::VOICES];
	bit              play_run [mvts_pkg::VOICES];
	int unsigned     beat_ticks_r;
	int unsigned     enable_r;
	int unsigned     len_r [mvts_pkg::VOICES];
	int unsigned     init_duty_r;

	mvts_pkg::evt_word_t due_events [$];
	mvts_pkg::evt_word_t new_events [$];
	row_t                directed_rows [$];
	mvts_pkg::evt_word_t got_word;
	mvts_pkg::evt_word_t want_word;

	int fails        = 0;
	int items_sent   = 0;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	bit hold_req     = 1'b0;
	bit hold_used    = 1'b0;
	int hold_left    = 0;

	multi_voice_tone_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_word  (cmd_word),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt_word  (evt_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		#4000000;
		$display("multi_voice_tone_sequencer regression: fail");
		$finish;
	end

	function automatic int unsigned eff_len(int v);
		return (len_r[v] > mvts_pkg::NOTES) ? mvts_pkg::NOTES : len_r[v];
	endfunction

	function automatic bit has_notes(int v);
		return ((enable_r >> v) & 1) != 0 && play_pos[v] < eff_len(v);
	endfunction

	// Start level in 16.16: base times a Q1.8 duty, clipped to 32 bits.
	function automatic logic [31:0] scaled_level(logic [15:0] base, logic [8:0] duty);
		longint unsigned x;
		x = (longint'(base) * longint'(duty)) << 8;
		return (x > 64'hFFFFFFFF) ? 32'hFFFFFFFF : x[31:0];
	endfunction

	function automatic logic [31:0] note_level(int v, int unsigned p, bit first);
		mvts_pkg::note_t n;
		if (p >= eff_len(v))
			return '0;
		n = notes_mem[v*mvts_pkg::NOTES + p];
		return scaled_level(n.base, first ? init_duty_r[8:0] : n.duty);
	endfunction

	function automatic void next_note(int v);
		play_pos[v]++;
		play_ela[v] = 0;
		play_lvl[v] = note_level(v, play_pos[v], 1'b0);
	endfunction

	function automatic void clear_play();
		for (int i = 0; i < mvts_pkg::VOICES; i++) begin
			play_pos[i] = 0;
			play_ela[i] = 0;
			play_lvl[i] = '0;
			play_run[i] = 1'b0;
		end
	endfunction

	// One tick: walk the voices, decay levels, advance notes and sync rests.
	function automatic void play_tick();
		bit                  any;
		bit                  all_sync;
		mvts_pkg::note_t     n;
		longint unsigned     lv;
		longint unsigned     thr;
		mvts_pkg::evt_word_t e;
		any = 1'b0;
		for (int p = 0; p < mvts_pkg::VOICES; p++)
			if (has_notes(p))
				any = 1'b1;
		if (!any) begin
			clear_play();
			e = '0;
			e.event_kind = mvts_pkg::EV_DONE;
			e.last_of_tick = 1'b1;
			new_events.push_back(e);
			return;
		end
		for (int p = 0; p < mvts_pkg::VOICES; p++) begin
			if (((enable_r >> p) & 1) == 0)
				continue;
			e = '0;
			e.out_voice = 3'(p);
			if (play_pos[p] >= eff_len(p)) begin
				play_run[p] = 1'b0;
				e.event_kind = mvts_pkg::EV_STOP;
				new_events.push_back(e);
				continue;
			end
			n = notes_mem[p*mvts_pkg::NOTES + play_pos[p]];
			lv = play_lvl[p];
			if (lv * 1000 >= longint'(n.base) * 65536)
				play_lvl[p] = 32'(lv * 99 / 100);
			else
				play_lvl[p] = '0;
			e.event_kind = mvts_pkg::EV_DRIVE;
			e.out_tone = n.tone;
			e.timer_off = (n.beats == 0);
			e.pulse_level = (n.kind != mvts_pkg::KIND_SOUND) ? 16'd0 : play_lvl[p][31:16];
			e.force_update = (play_ela[p] == 0);
			new_events.push_back(e);
			if (play_ela[p] < ELA_MAX)
				play_ela[p]++;
			if (n.kind == mvts_pkg::KIND_SYNC) begin
				all_sync = 1'b1;
				for (int i = 0; i < mvts_pkg::VOICES; i++)
					if (has_notes(i) && notes_mem[i*mvts_pkg::NOTES + play_pos[i]].kind
						!= mvts_pkg::KIND_SYNC)
						all_sync = 1'b0;
				if (all_sync)
					for (int i = 0; i < mvts_pkg::VOICES; i++)
						if (has_notes(i))
							next_note(i);
			end else begin
				thr = longint'(n.beats) * longint'(beat_ticks_r);
				if (play_ela[p] >= thr)
					next_note(p);
			end
		end
		if (new_events.size() > 0) begin
			e = new_events[new_events.size()-1];
			e.last_of_tick = 1'b1;
			new_events[new_events.size()-1] = e;
		end
	endfunction

	// Predict the event words caused by one accepted command word.
	function automatic void step_model(mvts_pkg::cmd_word_t w);
		mvts_pkg::note_t n;
		new_events.delete();
		case (w.command)
			mvts_pkg::CMD_LOAD: begin
				if (w.voice < mvts_pkg::VOICES) begin
					n.tone = w.tone_code;
					n.kind = w.note_kind;
					n.beats = w.beats;
					n.base = w.base_volume;
					n.duty = w.first_duty;
					notes_mem[w.voice*mvts_pkg::NOTES + w.note_index] = n;
				end
			end
			mvts_pkg::CMD_START: begin
				for (int i = 0; i < mvts_pkg::VOICES; i++)
					if (((enable_r >> i) & 1) != 0 && !play_run[i]) begin
						play_lvl[i] = note_level(i, 0, 1'b1);
						play_run[i] = 1'b1;
					end
			end
			mvts_pkg::CMD_TICK: play_tick();
			default: ;
		endcase
	endfunction

	function automatic void apply_reg(logic [mvts_pkg::CFG_IDX_W-1:0] idx,
		logic [mvts_pkg::CFG_DAT_W-1:0] data);
		case (idx)
			mvts_pkg::CFG_BEAT_TICKS: beat_ticks_r = data;
			mvts_pkg::CFG_ENABLE:     enable_r = data[4:0];
			mvts_pkg::CFG_INIT_DUTY:  init_duty_r = data[8:0];
			default:                  len_r[idx - mvts_pkg::CFG_LEN0] = data[8:0];
		endcase
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	function automatic mvts_pkg::cmd_word_t note_word(logic [2:0] v, logic [7:0] idx,
		logic [6:0] tone, logic [1:0] kind, logic [7:0] beats, logic [15:0] base,
		logic [8:0] duty);
		mvts_pkg::cmd_word_t w;
		w = '{mvts_pkg::CMD_LOAD, v, idx, tone, kind, beats, base, duty};
		return w;
	endfunction

	function automatic mvts_pkg::cmd_word_t op_word(logic [1:0] cmd);
		mvts_pkg::cmd_word_t w;
		w = mvts_pkg::cmd_word_t'({$urandom, $urandom});
		w.command = cmd;
		return w;
	endfunction

	// Random note content, with an occasional long note and an unused kind.
	function automatic mvts_pkg::cmd_word_t random_note(int v, int idx);
		logic [1:0]  kind;
		logic [7:0]  beats;
		logic [15:0] base;
		int          r;
		r = $urandom_range(19);
		kind = (r < 11) ? mvts_pkg::KIND_SOUND : (r < 15) ? mvts_pkg::KIND_EMPTY
			: (r < 19) ? mvts_pkg::KIND_SYNC : 2'd3;
		beats = ($urandom_range(11) == 0) ? 8'd255 : 8'($urandom_range(3));
		r = $urandom_range(7);
		base = (r == 0) ? 16'hFFFF : (r == 1) ? 16'd0 : 16'($urandom);
		return note_word(3'(v), 8'(idx), 7'($urandom_range(127)), kind, beats, base,
			9'($urandom_range(256)));
	endfunction

	// Loads to anywhere, including voices past the last, or an unused command.
	function automatic mvts_pkg::cmd_word_t noise_word();
		return op_word(($urandom_range(1) == 0) ? mvts_pkg::CMD_LOAD : CMD_NONE);
	endfunction

	function automatic row_t cfg_row(logic [mvts_pkg::CFG_IDX_W-1:0] idx,
		logic [mvts_pkg::CFG_DAT_W-1:0] data);
		row_t r;
		r = '{1'b1, idx, data, '0, 1'b0, '0};
		return r;
	endfunction

	function automatic row_t item_row(mvts_pkg::cmd_word_t w);
		row_t r;
		r = '{1'b0, '0, '0, w, 1'b0, '0};
		return r;
	endfunction

	// Offer one command word, idling first at the current rate, and predict its results.
	task automatic send_word(mvts_pkg::cmd_word_t w, bit typed = 1'b0,
		mvts_pkg::evt_word_t want = '0);
		if ($urandom_range(99) < snd_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < snd_idle_pct)
				@(posedge clk);
		end
		cmd_word <= w;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		step_model(w);
		items_sent++;
		if (typed)
			due_events.push_back(want);
		else
			foreach (new_events[i])
				due_events.push_back(new_events[i]);
	endtask

	task automatic wait_idle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (due_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [mvts_pkg::CFG_IDX_W-1:0] idx,
		logic [mvts_pkg::CFG_DAT_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Start the song and tick until it finishes or the tick budget runs out.
	task automatic play_song(int max_ticks);
		send_word(op_word(mvts_pkg::CMD_START));
		for (int t = 0; t < max_ticks; t++) begin
			if ($urandom_range(9) == 0)
				send_word(noise_word());
			if ($urandom_range(19) == 0)
				send_word(op_word(mvts_pkg::CMD_START));
			send_word(op_word(mvts_pkg::CMD_TICK));
			if (new_events.size() == 1 && new_events[0].event_kind == mvts_pkg::EV_DONE)
				break;
		end
	endtask

	// One song: idle-time register setup, note loads for the live voices, then play.
	// On request the receiver holds off for a long stretch as the song starts to play.
	task automatic run_song(bit hold_song);
		int          lens [mvts_pkg::VOICES];
		logic [4:0]  en;
		int          r;
		int unsigned bt;
		int unsigned duty;
		wait_idle();
		r = $urandom_range(7);
		bt = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(1, 3);
		r = $urandom_range(7);
		en = (r == 0) ? 5'd0 : (r == 1) ? 5'h1F : 5'($urandom);
		for (int v = 0; v < mvts_pkg::VOICES; v++)
			lens[v] = $urandom_range(6);
		r = $urandom_range(5);
		duty = (r == 0) ? 0 : (r == 1) ? 256 : (r == 2) ? 511 : $urandom_range(256);
		write_reg(mvts_pkg::CFG_BEAT_TICKS, 16'(bt));
		write_reg(mvts_pkg::CFG_ENABLE, {11'($urandom), en});
		for (int v = 0; v < mvts_pkg::VOICES; v++)
			write_reg(mvts_pkg::CFG_LEN0 + 3'(v), {7'($urandom), 9'(lens[v])});
		write_reg(mvts_pkg::CFG_INIT_DUTY, {7'($urandom), 9'(duty)});
		for (int v = 0; v < mvts_pkg::VOICES; v++) begin
			if (!en[v])
				continue;
			for (int i = 0; i < lens[v]; i++) begin
				if ($urandom_range(9) == 0)
					send_word(noise_word());
				send_word(random_note(v, i));
			end
		end
		if (hold_song)
			hold_req <= 1'b1;
		play_song(40);
	endtask

	// Result checking against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && evt_valid && evt_ready) begin
			got_word = evt_word;
			if (due_events.size() == 0) begin
				$error("event word %h arrived with none expected", got_word);
				fails++;
			end else begin
				want_word = due_events.pop_front();
				check_field("event_kind", want_word.event_kind, got_word.event_kind);
				check_field("out_voice", want_word.out_voice, got_word.out_voice);
				check_field("out_tone", want_word.out_tone, got_word.out_tone);
				check_field("timer_off", want_word.timer_off, got_word.timer_off);
				check_field("pulse_level", want_word.pulse_level, got_word.pulse_level);
				check_field("force_update", want_word.force_update, got_word.force_update);
				check_field("last_of_tick", want_word.last_of_tick, got_word.last_of_tick);
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_ready <= 1'b0;
		end else if (hold_req && !hold_used) begin
			hold_used <= 1'b1;
			hold_left <= HOLD_CYCLES;
			evt_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			evt_ready <= 1'b0;
		end else begin
			evt_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	initial begin
		mvts_pkg::evt_word_t done_word;
		int                  song;
		clear_play();
		beat_ticks_r = 1;
		enable_r = 0;
		init_duty_r = 128;
		foreach (len_r[i])
			len_r[i] = 0;
		done_word = '0;
		done_word.event_kind = mvts_pkg::EV_DONE;
		done_word.last_of_tick = 1'b1;

		// Directed part: reset behavior, ignored words, extremes, sync and empty voices.
		directed_rows.push_back(item_row(op_word(mvts_pkg::CMD_TICK)));
		directed_rows[0].typed = 1'b1;
		directed_rows[0].want = done_word;
		directed_rows.push_back(item_row(mvts_pkg::cmd_word_t'('1)));
		directed_rows.push_back(item_row(note_word(3'd5, 8'd0, 7'd1, mvts_pkg::KIND_SOUND,
			8'd1, 16'd1, 9'd1)));
		directed_rows.push_back(item_row(note_word(3'd7, 8'd255, 7'd127, mvts_pkg::KIND_SYNC,
			8'd255, 16'hFFFF, 9'd256)));
		directed_rows.push_back(cfg_row(mvts_pkg::CFG_BEAT_TICKS, 16'd0));
		directed_rows.push_back(cfg_row(mvts_pkg::CFG_ENABLE, 16'h001F));
		directed_rows.push_back(cfg_row(mvts_pkg::CFG_LEN0, 16'd2));
		directed_rows.push_back(cfg_row(mvts_pkg::CFG_LEN0 + 3'd1, 16'd1));
		directed_rows.push_back(cfg_row(mvts_pkg::CFG_LEN0 + 3'd2, 16'd1));
		directed_rows.push_back(cfg_row(mvts_pkg::CFG_LEN0 + 3'd3, 16'd1));
		directed_rows.push_back(cfg_row(mvts_pkg::CFG_LEN0 + 3'd4, 16'd0));
		directed_rows.push_back(cfg_row(mvts_pkg::CFG_INIT_DUTY, 16'd511));
		directed_rows.push_back(item_row(note_word(3'd0, 8'd0, 7'd127, mvts_pkg::KIND_SOUND,
			8'd255, 16'hFFFF, 9'd256)));
		directed_rows.push_back(item_row(note_word(3'd0, 8'd1, 7'd0, mvts_pkg::KIND_SOUND,
			8'd0, 16'd0, 9'd0)));
		directed_rows.push_back(item_row(note_word(3'd1, 8'd0, 7'd60, mvts_pkg::KIND_SYNC,
			8'd3, 16'd1000, 9'd128)));
		directed_rows.push_back(item_row(note_word(3'd2, 8'd0, 7'd64, mvts_pkg::KIND_SYNC,
			8'd2, 16'd20000, 9'd200)));
		directed_rows.push_back(item_row(note_word(3'd3, 8'd0, 7'd33, mvts_pkg::KIND_EMPTY,
			8'd1, 16'd500, 9'd100)));
		directed_rows.push_back(item_row(op_word(mvts_pkg::CMD_START)));
		directed_rows.push_back(item_row(op_word(mvts_pkg::CMD_START)));
		repeat (5) directed_rows.push_back(item_row(op_word(mvts_pkg::CMD_TICK)));

		snd_idle_pct = 26;
		rcv_idle_pct <= 63;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				wait_idle();
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				send_word(directed_rows[i].word, directed_rows[i].typed,
					directed_rows[i].want);
			end
		end

		// Random songs under the three idling phases; one song plays under a long hold-off.
		song = 0;
		while (items_sent < 360) begin
			if (items_sent < 120) begin
				snd_idle_pct = 26;
				rcv_idle_pct <= 63;
			end else if (items_sent < 240) begin
				snd_idle_pct = 63;
				rcv_idle_pct <= 26;
			end else begin
				snd_idle_pct = 0;
				rcv_idle_pct <= 0;
			end
			run_song(song == 3);
			song++;
		end

		wait_idle();
		if (fails == 0)
			$display("multi_voice_tone_sequencer regression: pass");
		else
			$display("multi_voice_tone_sequencer regression: fail");
		$finish;
	end

endmodule
